FILE: rtl/apr_pkg.sv
// package: shared constants, types and helpers of the periodic adc ascii reporter
`timescale 1ns / 1ps
package apr_pkg;

  // ring of transmit bytes, one slot always left empty
  localparam int RING_SLOTS = 8;
  localparam int SLOT_W     = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;

  localparam int PERIOD_W   = 16;
  localparam int SAMPLE_W   = 10;
  localparam int BYTE_W     = 8;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd100;

  // ascii codes of a report
  localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] BYTE_DOT  = 8'h2E;
  localparam logic [BYTE_W-1:0] BYTE_LF   = 8'h0A;

  // position of a byte within one report
  localparam int IDX_W = 3;
  localparam logic [IDX_W-1:0] IDX_HUND = 3'd0;
  localparam logic [IDX_W-1:0] IDX_DOT  = 3'd1;
  localparam logic [IDX_W-1:0] IDX_TENS = 3'd2;
  localparam logic [IDX_W-1:0] IDX_ONES = 3'd3;
  localparam logic [IDX_W-1:0] IDX_LF   = 3'd4;

  // three digit characters of a scaled sample
  typedef struct packed {
    logic [BYTE_W-1:0] hund_char;
    logic [BYTE_W-1:0] tens_char;
    logic [BYTE_W-1:0] ones_char;
  } apr_digits_t;

  // ring slot advance with wrap
  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == SLOT_W'(RING_SLOTS - 1)) begin
      r = '0;
    end else begin
      r = s + 1'b1;
    end
    return r;
  endfunction

endpackage

FILE: rtl/apr_ring_ram.sv
// module: single port write, single port read ram with registered read data
`timescale 1ns / 1ps
module apr_ring_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 8
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, read data registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/apr_scale.sv
// module: four stage pipeline from adc sample to three ascii digits of 500*sample/1023
`timescale 1ns / 1ps
module apr_scale (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [apr_pkg::SAMPLE_W-1:0]    sample,
  output logic                            done,
  output apr_pkg::apr_digits_t            digits
);

  logic [18:0] prod_r;
  logic [8:0]  volt_r;
  logic [8:0]  volt_nxt;
  logic [2:0]  hund_r;
  logic [2:0]  hund_nxt;
  logic [6:0]  rem_r;
  logic [6:0]  rem_nxt;
  logic [3:0]  tens_nxt;
  logic [3:0]  ones_nxt;
  logic [8:0]  quot_lo;
  logic [10:0] quot_rem;
  logic [8:0]  hund_sub;
  logic [6:0]  tens_sub;
  logic        stg1_r;
  logic        stg2_r;
  logic        stg3_r;
  logic        stg4_r;
  apr_pkg::apr_digits_t digits_r;
  apr_pkg::apr_digits_t digits_nxt;

  // stage valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg1_r <= 1'b0;
      stg2_r <= 1'b0;
      stg3_r <= 1'b0;
      stg4_r <= 1'b0;
    end else begin
      stg1_r <= start;
      stg2_r <= stg1_r;
      stg3_r <= stg2_r;
      stg4_r <= stg3_r;
    end
  end

  // divide by 1023: p = q*1024 + lo = q*1023 + (q + lo), one correction step
  always_comb begin
    quot_lo  = prod_r[18:10];
    quot_rem = {1'b0, prod_r[9:0]} + {2'b00, quot_lo};
    if (quot_rem >= 11'd1023) begin
      volt_nxt = quot_lo + 9'd1;
    end else begin
      volt_nxt = quot_lo;
    end
  end

  // hundreds digit by compare against multiples of 100
  always_comb begin
    if (volt_r >= 9'd500) begin
      hund_nxt = 3'd5;
      hund_sub = 9'd500;
    end else if (volt_r >= 9'd400) begin
      hund_nxt = 3'd4;
      hund_sub = 9'd400;
    end else if (volt_r >= 9'd300) begin
      hund_nxt = 3'd3;
      hund_sub = 9'd300;
    end else if (volt_r >= 9'd200) begin
      hund_nxt = 3'd2;
      hund_sub = 9'd200;
    end else if (volt_r >= 9'd100) begin
      hund_nxt = 3'd1;
      hund_sub = 9'd100;
    end else begin
      hund_nxt = 3'd0;
      hund_sub = 9'd0;
    end
    rem_nxt = 7'(volt_r - hund_sub);
  end

  // tens and ones digits of the remainder below 100
  always_comb begin
    tens_nxt = 4'd0;
    tens_sub = 7'd0;
    for (int k = 9; k >= 1; k--) begin
      if (tens_nxt == 4'd0 && rem_r >= 7'(k * 10)) begin
        tens_nxt = 4'(k);
        tens_sub = 7'(k * 10);
      end
    end
    ones_nxt = 4'(rem_r - tens_sub);
    digits_nxt.hund_char = apr_pkg::CHAR_ZERO + {5'd0, hund_r};
    digits_nxt.tens_char = apr_pkg::CHAR_ZERO + {4'd0, tens_nxt};
    digits_nxt.ones_char = apr_pkg::CHAR_ZERO + {4'd0, ones_nxt};
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= {9'd0, sample} * 19'd500;
    end
    if (stg1_r) begin
      volt_r <= volt_nxt;
    end
    if (stg2_r) begin
      hund_r <= hund_nxt;
      rem_r  <= rem_nxt;
    end
    if (stg3_r) begin
      digits_r <= digits_nxt;
    end
  end

  assign done   = stg4_r;
  assign digits = digits_r;

endmodule

FILE: rtl/periodic_adc_ascii_reporter_core.sv
// top level: tick counter, report sequencer and transmit ring of the adc ascii reporter
//
//   channel | ports                              | moves
//   --------+------------------------------------+--------------------------------
//   in      | in_valid in_stall in_func          | event item: tick or tx done
//           | in_adc_sample                      |
//   out     | out_valid out_stall out_tx_byte    | byte for the serial transmitter
//   cfg     | cfg_we cfg_wdata                   | report period write
//
// a tick that fires no report and a done event on an empty ring are taken in idle;
// a done event that reads a byte from the ring ram goes through a read state.
// a report tick runs the 4 stages of the scaling pipeline, then one ring write a cycle
// for the five report bytes (dropped when full), held while one due out finds it busy.
// reset is synchronous and active low; the ring ram is not cleared, since a slot
// is only read after it was written.
// a stalled output holds the sequencer in place only when it has a byte to hand out.
`timescale 1ns / 1ps
module periodic_adc_ascii_reporter_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_func,
  input  logic [apr_pkg::SAMPLE_W-1:0]      in_adc_sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [apr_pkg::BYTE_W-1:0]        out_tx_byte,
  input  logic                              cfg_we,
  input  logic [apr_pkg::PERIOD_W-1:0]      cfg_wdata
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_RD_OUT = 2'd1;
  localparam logic [1:0] S_CONV   = 2'd2;
  localparam logic [1:0] S_WR     = 2'd3;

  logic [1:0]                    state_r;
  logic [1:0]                    state_nxt;
  logic [apr_pkg::PERIOD_W-1:0]  period_r;
  logic [apr_pkg::PERIOD_W-1:0]  tick_cnt_r;
  logic [apr_pkg::PERIOD_W-1:0]  tick_cnt_nxt;
  logic [apr_pkg::PERIOD_W-1:0]  tick_inc;
  logic [apr_pkg::SLOT_W-1:0]    wr_slot_r;
  logic [apr_pkg::SLOT_W-1:0]    wr_slot_nxt;
  logic [apr_pkg::SLOT_W-1:0]    rd_slot_r;
  logic [apr_pkg::SLOT_W-1:0]    rd_slot_nxt;
  logic                          busy_r;
  logic                          busy_nxt;
  logic [apr_pkg::IDX_W-1:0]     byte_idx_r;
  logic [apr_pkg::IDX_W-1:0]     byte_idx_nxt;
  logic                          out_valid_r;
  logic [apr_pkg::BYTE_W-1:0]    out_byte_r;
  logic                          out_free;
  logic                          out_load;
  logic [apr_pkg::BYTE_W-1:0]    out_load_byte;
  logic                          in_accept;
  logic                          ring_empty;
  logic                          ring_full;
  logic                          emit_now;
  logic                          wr_go;
  logic [apr_pkg::BYTE_W-1:0]    report_byte;
  logic                          ram_we;
  logic                          ram_re;
  logic [apr_pkg::BYTE_W-1:0]    ram_rd_data;
  logic                          scale_start;
  logic                          scale_done;
  apr_pkg::apr_digits_t          scale_digits;

  // scaling pipeline
  apr_scale u_scale (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (scale_start),
    .sample (in_adc_sample),
    .done   (scale_done),
    .digits (scale_digits)
  );

  // transmit ring storage
  apr_ring_ram #(
    .DEPTH (apr_pkg::RING_SLOTS),
    .WIDTH (apr_pkg::BYTE_W)
  ) u_ring_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wr_slot_r),
    .wr_data (report_byte),
    .rd_en   (ram_re),
    .rd_addr (rd_slot_r),
    .rd_data (ram_rd_data)
  );

  assign in_stall   = (state_r != S_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign ring_empty = (wr_slot_r == rd_slot_r);
  assign ring_full  = (apr_pkg::next_slot(wr_slot_r) == rd_slot_r);
  assign tick_inc   = tick_cnt_r + 16'd1;

  // byte of the report at the current position
  always_comb begin
    unique case (byte_idx_r)
      apr_pkg::IDX_HUND: report_byte = scale_digits.hund_char;
      apr_pkg::IDX_DOT:  report_byte = apr_pkg::BYTE_DOT;
      apr_pkg::IDX_TENS: report_byte = scale_digits.tens_char;
      apr_pkg::IDX_ONES: report_byte = scale_digits.ones_char;
      apr_pkg::IDX_LF:   report_byte = apr_pkg::BYTE_LF;
      default:           report_byte = apr_pkg::BYTE_LF;
    endcase
  end

  // an idle transmitter takes the written byte at once, so it skips the ram read
  assign emit_now = !ring_full && !busy_r;
  assign wr_go    = !emit_now || out_free;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    tick_cnt_nxt  = tick_cnt_r;
    wr_slot_nxt   = wr_slot_r;
    rd_slot_nxt   = rd_slot_r;
    busy_nxt      = busy_r;
    byte_idx_nxt  = byte_idx_r;
    out_load      = 1'b0;
    out_load_byte = ram_rd_data;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    scale_start   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if (in_func) begin
            if (!ring_empty) begin
              ram_re      = 1'b1;
              rd_slot_nxt = apr_pkg::next_slot(rd_slot_r);
              state_nxt   = S_RD_OUT;
            end else begin
              busy_nxt = 1'b0;
            end
          end else if (tick_inc == period_r) begin
            tick_cnt_nxt = '0;
            scale_start  = 1'b1;
            byte_idx_nxt = apr_pkg::IDX_HUND;
            state_nxt    = S_CONV;
          end else begin
            tick_cnt_nxt = tick_inc;
          end
        end
      end
      S_RD_OUT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_CONV: begin
        if (scale_done) begin
          state_nxt = S_WR;
        end
      end
      S_WR: begin
        if (wr_go) begin
          if (!ring_full) begin
            ram_we      = 1'b1;
            wr_slot_nxt = apr_pkg::next_slot(wr_slot_r);
          end
          if (emit_now) begin
            busy_nxt      = 1'b1;
            rd_slot_nxt   = apr_pkg::next_slot(rd_slot_r);
            out_load      = 1'b1;
            out_load_byte = report_byte;
          end
          byte_idx_nxt = byte_idx_r + 1'b1;
          if (byte_idx_r == apr_pkg::IDX_LF) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tick_cnt_r  <= '0;
      wr_slot_r   <= '0;
      rd_slot_r   <= '0;
      busy_r      <= 1'b0;
      byte_idx_r  <= apr_pkg::IDX_HUND;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      tick_cnt_r <= tick_cnt_nxt;
      wr_slot_r  <= wr_slot_nxt;
      rd_slot_r  <= rd_slot_nxt;
      busy_r     <= busy_nxt;
      byte_idx_r <= byte_idx_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // report period register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= apr_pkg::PERIOD_RESET;
    end else if (cfg_we) begin
      period_r <= cfg_wdata;
    end
  end

  // output byte register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte_r <= out_load_byte;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_tx_byte = out_byte_r;

  // an idle transmitter means nothing waits in the ring
  a_idle_ring_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (wr_slot_r == rd_slot_r))
    else $error("transmitter idle with bytes left in the ring");

  // ring writes come only from the report sequence
  a_write_in_report: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_WR))
    else $error("ring write outside the report sequence");

  // the scaling pipeline finishes only while the sequencer waits for it
  a_scale_done_conv: assert property (@(posedge clk) disable iff (!rst_n)
    scale_done |-> (state_r == S_CONV))
    else $error("scaled digits arrived while not waiting");

  // a ring byte read out lands in the output register and frees the input
  a_read_delivered: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD_OUT) && out_free |=> (state_r == S_IDLE) && out_valid_r)
    else $error("ring byte not handed to the output");

  // slot pointers stay inside the ring
  a_slots_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, wr_slot_r} < (apr_pkg::SLOT_W + 1)'(apr_pkg::RING_SLOTS)) &&
    ({1'b0, rd_slot_r} < (apr_pkg::SLOT_W + 1)'(apr_pkg::RING_SLOTS)))
    else $error("ring slot pointer out of range");

endmodule

FILE: dv/apr_tx_checker.sv
// checker: predicts the transmit bytes of the adc reporter and compares them with the output
`timescale 1ns / 1ps
module apr_tx_checker #(
  parameter logic EV_DONE = 1'b1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic                         in_func,
  input  logic [apr_pkg::SAMPLE_W-1:0] in_adc_sample,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [apr_pkg::BYTE_W-1:0]   out_tx_byte,
  input  logic                         cfg_we,
  input  logic [apr_pkg::PERIOD_W-1:0] cfg_wdata,
  output int                           bytes_due,
  output int                           fail_count
);
  import apr_pkg::*;

  // predicted reporter state
  logic [PERIOD_W-1:0] period_q;
  logic [PERIOD_W-1:0] tick_q;
  logic [BYTE_W-1:0]   ring_q [RING_SLOTS];
  int                  wr_slot;
  int                  rd_slot;
  bit                  tx_busy;

  // bytes the transmitter side should see, oldest first
  logic [BYTE_W-1:0]   tx_bytes_due [$];
  logic [BYTE_W-1:0]   due_byte;

  function automatic int slot_after(input int s);
    return (s + 1) % RING_SLOTS;
  endfunction

  // one report byte into the ring; goes straight out when the transmitter is idle
  function automatic void queue_report_byte(input logic [BYTE_W-1:0] b);
    if (slot_after(wr_slot) != rd_slot) begin
      ring_q[wr_slot] = b;
      wr_slot = slot_after(wr_slot);
      if (!tx_busy) begin
        tx_busy = 1'b1;
        tx_bytes_due.push_back(ring_q[rd_slot]);
        rd_slot = slot_after(rd_slot);
      end
    end
  endfunction

  // state update for one accepted event item
  function automatic void predict_event(input logic ev, input logic [SAMPLE_W-1:0] sample);
    int volts;
    if (ev == EV_DONE) begin
      if (wr_slot != rd_slot) begin
        tx_bytes_due.push_back(ring_q[rd_slot]);
        rd_slot = slot_after(rd_slot);
      end else begin
        tx_busy = 1'b0;
      end
    end else begin
      tick_q = tick_q + 1'b1;
      if (tick_q == period_q) begin
        tick_q = '0;
        volts = (500 * int'(sample)) / 1023;
        queue_report_byte(CHAR_ZERO + BYTE_W'(volts / 100));
        queue_report_byte(BYTE_DOT);
        queue_report_byte(CHAR_ZERO + BYTE_W'((volts % 100) / 10));
        queue_report_byte(CHAR_ZERO + BYTE_W'(volts % 10));
        queue_report_byte(BYTE_LF);
      end
    end
  endfunction

  // watch both channels and the register port
  always @(posedge clk) begin
    if (!rst_n) begin
      period_q = PERIOD_RESET;
      tick_q   = '0;
      wr_slot  = 0;
      rd_slot  = 0;
      tx_busy  = 1'b0;
      tx_bytes_due.delete();
    end else begin
      if (cfg_we) begin
        period_q = cfg_wdata;
      end
      if (in_valid && !in_stall) begin
        predict_event(in_func, in_adc_sample);
      end
      if (out_valid && !out_stall) begin
        if (tx_bytes_due.size() == 0) begin
          $display("%0t tx_byte expected none actual %02h", $time, out_tx_byte);
          fail_count = fail_count + 1;
        end else begin
          due_byte = tx_bytes_due.pop_front();
          if (out_tx_byte !== due_byte) begin
            $display("%0t tx_byte expected %02h actual %02h", $time, due_byte, out_tx_byte);
            fail_count = fail_count + 1;
          end
        end
      end
    end
    bytes_due = tx_bytes_due.size();
  end

endmodule

FILE: dv/tb_top.sv
// testbench top: clock, reset, event and register stimulus, and the verdict
`timescale 1ns / 1ps
module tb_top;
  import apr_pkg::*;

  localparam logic EV_TICK = 1'b0;
  localparam logic EV_DONE = 1'b1;

  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                in_valid      = 1'b0;
  logic                in_stall;
  logic                in_func       = EV_TICK;
  logic [SAMPLE_W-1:0] in_adc_sample = '0;
  logic                out_valid;
  logic                out_stall     = 1'b0;
  logic [BYTE_W-1:0]   out_tx_byte;
  logic                cfg_we        = 1'b0;
  logic [PERIOD_W-1:0] cfg_wdata     = '0;

  int bytes_due;
  int fail_count;

  // idle rates in percent, and a request for a long receiver hold-off
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  bit hold_req     = 1'b0;
  int hold_left    = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  periodic_adc_ascii_reporter_core u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_adc_sample (in_adc_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_tx_byte   (out_tx_byte),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  apr_tx_checker #(
    .EV_DONE (EV_DONE)
  ) u_tx_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_adc_sample (in_adc_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_tx_byte   (out_tx_byte),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .bytes_due     (bytes_due),
    .fail_count    (fail_count)
  );

  // serial transmitter side: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 400;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end
  end

  // run limit
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return '0;
    end else if (r == 1) begin
      return '1;
    end
    return SAMPLE_W'($urandom_range(0, 1023));
  endfunction

  // offer one event item and hold it until accepted
  task automatic send_event(input logic ev, input logic [SAMPLE_W-1:0] sample);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= ev;
    in_adc_sample <= sample;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_event(EV_TICK, pick_sample());
  endtask

  task automatic send_dones(input int n);
    repeat (n) send_event(EV_DONE, pick_sample());
  endtask

  // stop offering, wait for every due byte, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (bytes_due != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_period(input logic [PERIOD_W-1:0] p);
    cfg_we    <= 1'b1;
    cfg_wdata <= p;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly runs of up to one period of ticks followed by done events, some loose items
  task automatic run_mix(input int n_items, input int period);
    int sent;
    int burst;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 80) begin
        burst = $urandom_range(1, period);
        send_ticks(burst);
        sent = sent + burst;
        burst = $urandom_range(2, 7);
        send_dones(burst);
        sent = sent + burst;
      end else begin
        send_event(1'($urandom_range(0, 1)), pick_sample());
        sent = sent + 1;
      end
    end
  endtask

  initial begin
    int seg_period [9];
    seg_period = '{1, 2, 3, 5, 1, 4, 1, 2, 7};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every tick reports
    write_period(16'd1);
    snd_idle_pct = 35;
    rcv_idle_pct = 68;
    // done while idle, then a full ring with dropped bytes, then drained
    send_event(EV_DONE, '0);
    send_event(EV_TICK, 10'd0);
    send_event(EV_TICK, 10'd1023);
    send_dones(8);
    send_event(EV_TICK, 10'd1);
    send_dones(5);
    send_event(EV_TICK, 10'd512);
    send_event(EV_TICK, 10'd205);
    send_dones(8);
    settle();

    // a raised period is met by the running count
    write_period(16'd3);
    send_ticks(2);
    settle();
    write_period(16'd5);
    send_ticks(3);
    send_dones(6);
    settle();

    // random segments under three idle patterns
    for (int seg = 0; seg < 9; seg++) begin
      if (seg < 3) begin
        snd_idle_pct = 35;
        rcv_idle_pct = 68;
      end else if (seg < 6) begin
        snd_idle_pct = 68;
        rcv_idle_pct = 35;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      write_period(PERIOD_W'(seg_period[seg]));
      if (seg == 6) begin
        // long receiver hold-off while reports keep coming
        @(negedge clk);
        hold_req = 1'b1;
        @(posedge clk);
        send_ticks(12);
        send_dones(3);
      end
      run_mix(90, seg_period[seg]);
      settle();
    end

    // wait out the last bytes and the pipeline
    do @(negedge clk); while (bytes_due != 0);
    repeat (30) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
